/* hw/rtl/hwc_pkg.sv */
package hwc_pkg;

  localparam int MAX_WINDOW   = 4096;
  localparam int FRAC_BITS    = 15;
  localparam int WS_W         = 13;
  localparam int IDX_W        = 12;
  localparam int COEF_W       = 16;
  localparam int DIV_STEPS    = 32;
  localparam int CORDIC_STEPS = 28;
  localparam int XY_W         = 34;
  localparam int Z_W          = 33;
  localparam int QUARTER_BITS = 30;
  localparam logic signed [XY_W-1:0] CORDIC_X0 = 34'sd652032874;

  localparam logic REG_WINDOW_SIZE = 1'b0;
  localparam logic REG_PERIODIC    = 1'b1;

  typedef struct packed {
    logic [WS_W-1:0]      rem;
    logic [DIV_STEPS-1:0] quo;
    logic                 oor;
    logic                 last;
    logic                 zph;
  } div_item_t;

  typedef struct packed {
    logic signed [XY_W-1:0] x;
    logic signed [XY_W-1:0] y;
    logic signed [Z_W-1:0]  z;
    logic [1:0]             quad;
    logic                   oor;
    logic                   last;
  } cordic_item_t;

  // Arctangent of 2^-i in units of 2^-32 turn.
  function automatic logic signed [Z_W-1:0] atan_turn(input int i);
    logic signed [Z_W-1:0] a;
    unique case (i)
      0:  a = 33'sd536870912;
      1:  a = 33'sd316933406;
      2:  a = 33'sd167458907;
      3:  a = 33'sd85004756;
      4:  a = 33'sd42667331;
      5:  a = 33'sd21354465;
      6:  a = 33'sd10679838;
      7:  a = 33'sd5340245;
      8:  a = 33'sd2670163;
      9:  a = 33'sd1335087;
      10: a = 33'sd667544;
      11: a = 33'sd333772;
      12: a = 33'sd166886;
      13: a = 33'sd83443;
      14: a = 33'sd41722;
      15: a = 33'sd20861;
      16: a = 33'sd10430;
      17: a = 33'sd5215;
      18: a = 33'sd2608;
      19: a = 33'sd1304;
      20: a = 33'sd652;
      21: a = 33'sd326;
      22: a = 33'sd163;
      23: a = 33'sd81;
      24: a = 33'sd41;
      25: a = 33'sd20;
      26: a = 33'sd10;
      27: a = 33'sd5;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

/* hw/rtl/hwc_div_cell.sv */
module hwc_div_cell #(
  parameter int STEP = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [hwc_pkg::WS_W-1:0] divisor,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  hwc_pkg::div_item_t     in_data,
  output logic                   out_valid,
  input  logic                   out_ready,
  output hwc_pkg::div_item_t     out_data
);
  import hwc_pkg::*;

  logic                 valid_r;
  div_item_t            data_r;
  div_item_t            data_nxt;
  logic [DIV_STEPS-1:0] low;
  logic [WS_W:0]        trial;
  logic [WS_W:0]        diff;
  logic                 qbit;

  // Low dividend word is the rounding term divisor/2.
  assign low   = {{(DIV_STEPS-WS_W+1){1'b0}}, divisor[WS_W-1:1]};
  assign trial = {in_data.rem, low[DIV_STEPS-1-STEP]};
  assign diff  = trial - {1'b0, divisor};
  assign qbit  = (trial >= {1'b0, divisor});

  always_comb begin
    data_nxt     = in_data;
    data_nxt.rem = qbit ? diff[WS_W-1:0] : trial[WS_W-1:0];
    data_nxt.quo = {in_data.quo[DIV_STEPS-2:0], qbit};
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* hw/rtl/hwc_cordic_cell.sv */
module hwc_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hwc_pkg::cordic_item_t in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hwc_pkg::cordic_item_t out_data
);
  import hwc_pkg::*;

  localparam logic signed [Z_W-1:0] ANGLE = atan_turn(STEP);

  logic                   valid_r;
  cordic_item_t           data_r;
  cordic_item_t           data_nxt;
  logic signed [XY_W-1:0] dx;
  logic signed [XY_W-1:0] dy;

  assign dx = in_data.y >>> STEP;
  assign dy = in_data.x >>> STEP;

  always_comb begin
    data_nxt = in_data;
    if (!in_data.z[Z_W-1]) begin
      data_nxt.x = in_data.x - dx;
      data_nxt.y = in_data.y + dy;
      data_nxt.z = in_data.z - ANGLE;
    end else begin
      data_nxt.x = in_data.x + dx;
      data_nxt.y = in_data.y - dy;
      data_nxt.z = in_data.z + ANGLE;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

/* hw/rtl/hann_window_coefficient.sv */
// Channel | Direction | Ports
// input   | in        | in_valid, in_ready, in_sample_index
// result  | out       | out_valid, out_ready, out_coefficient, out_last_index, out_out_of_range
// config  | in        | psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// One item is taken per cycle unless the result side stalls.
// Each result passes through 32 long-division cells, 28 CORDIC cells and one output register.
// Each cell stalls only when it is full and its neighbor is full and stalled.
// Synchronous active-low reset empties all cells and loads the register defaults.
module hann_window_coefficient (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [hwc_pkg::IDX_W-1:0]  in_sample_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [hwc_pkg::COEF_W-1:0] out_coefficient,
  output logic                       out_last_index,
  output logic                       out_out_of_range,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import hwc_pkg::*;

  logic [WS_W-1:0] window_size_r;
  logic            periodic_r;
  logic [WS_W-1:0] divisor;
  logic [WS_W-1:0] wr_size;
  logic            wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign wr_size = (pwdata[WS_W-1:0] > WS_W'(MAX_WINDOW)) ? WS_W'(MAX_WINDOW)
                                                          : pwdata[WS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_size_r <= WS_W'(1024);
      periodic_r    <= 1'b1;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_WINDOW_SIZE: window_size_r <= wr_size;
        REG_PERIODIC:    periodic_r    <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WINDOW_SIZE: prdata = {{(32-WS_W){1'b0}}, window_size_r};
      REG_PERIODIC:    prdata = {31'd0, periodic_r};
      default:         prdata = '0;
    endcase
  end

  assign divisor = periodic_r ? window_size_r : window_size_r - WS_W'(1);

  // Front end: the index itself is the first partial remainder.
  logic            n_oor;
  logic [WS_W-1:0] n_ext;
  div_item_t       front;

  assign n_ext = {{(WS_W-IDX_W){1'b0}}, in_sample_index};
  assign n_oor = (n_ext >= window_size_r);

  always_comb begin
    front.rem  = n_ext;
    front.quo  = '0;
    front.oor  = n_oor;
    front.last = (n_ext == window_size_r - WS_W'(1));
    // A zero divisor or the symmetric end point gives phase zero.
    front.zph  = (divisor == '0) || (n_ext >= divisor);
  end

  div_item_t div_d   [DIV_STEPS+1];
  logic      div_v   [DIV_STEPS+1];
  logic      div_rdy [DIV_STEPS+1];

  assign div_d[0] = front;
  assign div_v[0] = in_valid;
  assign in_ready = div_rdy[0];

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    hwc_div_cell #(.STEP(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .divisor   (divisor),
      .in_valid  (div_v[k]),
      .in_ready  (div_rdy[k]),
      .in_data   (div_d[k]),
      .out_valid (div_v[k+1]),
      .out_ready (div_rdy[k+1]),
      .out_data  (div_d[k+1])
    );
  end

  cordic_item_t cor_d   [CORDIC_STEPS+1];
  logic         cor_v   [CORDIC_STEPS+1];
  logic         cor_rdy [CORDIC_STEPS+1];
  logic [DIV_STEPS-1:0] phase;

  assign phase = div_d[DIV_STEPS].zph ? '0 : div_d[DIV_STEPS].quo;

  always_comb begin
    cor_d[0].x    = CORDIC_X0;
    cor_d[0].y    = '0;
    cor_d[0].z    = {{(Z_W-QUARTER_BITS){1'b0}}, phase[QUARTER_BITS-1:0]};
    cor_d[0].quad = phase[DIV_STEPS-1:QUARTER_BITS];
    cor_d[0].oor  = div_d[DIV_STEPS].oor;
    cor_d[0].last = div_d[DIV_STEPS].last;
  end
  assign cor_v[0]          = div_v[DIV_STEPS];
  assign div_rdy[DIV_STEPS] = cor_rdy[0];

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    hwc_cordic_cell #(.STEP(k)) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (cor_v[k]),
      .in_ready  (cor_rdy[k]),
      .in_data   (cor_d[k]),
      .out_valid (cor_v[k+1]),
      .out_ready (cor_rdy[k+1]),
      .out_data  (cor_d[k+1])
    );
  end

  // Output stage: unfold the quadrant and scale (1 - cos)/2 to Q1.15.
  cordic_item_t           fin;
  logic signed [XY_W-1:0] cos_v;
  logic signed [XY_W+1:0] v_raw;
  logic [31:0]            v_clamp;
  logic [32:0]            v_round;
  logic [COEF_W-1:0]      coef;
  logic                   out_valid_r;
  logic [COEF_W-1:0]      coef_r;
  logic                   last_r;
  logic                   oor_r;

  assign fin = cor_d[CORDIC_STEPS];

  always_comb begin
    unique case (fin.quad)
      2'd0:    cos_v = fin.x;
      2'd1:    cos_v = -fin.y;
      2'd2:    cos_v = -fin.x;
      default: cos_v = fin.y;
    endcase
    v_raw = (XY_W+2)'(64'sd1 << 30) - (XY_W+2)'(cos_v);
    if (v_raw < 0) begin
      v_clamp = '0;
    end else if (v_raw > (XY_W+2)'(64'sd1 << 31)) begin
      v_clamp = 32'h8000_0000;
    end else begin
      v_clamp = v_raw[31:0];
    end
    v_round = ({1'b0, v_clamp} + (33'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
    if (fin.oor) begin
      coef = '0;
    end else if (v_round > (33'd1 << FRAC_BITS)) begin
      coef = COEF_W'(1 << FRAC_BITS);
    end else begin
      coef = v_round[COEF_W-1:0];
    end
  end

  assign cor_rdy[CORDIC_STEPS] = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cor_rdy[CORDIC_STEPS]) begin
      out_valid_r <= cor_v[CORDIC_STEPS];
    end
    if (cor_rdy[CORDIC_STEPS] && cor_v[CORDIC_STEPS]) begin
      coef_r <= coef;
      last_r <= fin.last && !fin.oor;
      oor_r  <= fin.oor;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_coefficient  = coef_r;
  assign out_last_index   = last_r;
  assign out_out_of_range = oor_r;

`ifndef ASSERT_OFF
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_coefficient == '0)
    else $error("out-of-range result with nonzero coefficient");

  a_last_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_last_index && out_out_of_range))
    else $error("last index flagged on an out-of-range result");

  a_coef_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_coefficient <= COEF_W'(1 << FRAC_BITS))
    else $error("coefficient above 1.0");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");
`endif

endmodule

/* verif/tb_top.sv */
module tb_top;
  import hwc_pkg::*;

  typedef struct packed {
    logic [COEF_W-1:0] coefficient;
    logic              last_index;
    logic              out_of_range;
  } hann_result_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [IDX_W-1:0]  in_sample_index = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [COEF_W-1:0] out_coefficient;
  logic              out_last_index;
  logic              out_out_of_range;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  hann_window_coefficient dut (.*);

  always #5 clk = ~clk;

  // Register copies used by the predictor.
  int unsigned  win_size = 1024;
  bit           periodic = 1'b1;
  hann_result_t pending_coefs[$];
  int           fail_count = 0;
  int           result_count = 0;
  int           index_count = 0;
  int           setting_count = 0;
  bit           no_gaps = 1'b0;
  int           stall_left = 0;

  localparam longint ATAN_TBL[CORDIC_STEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10, 5};

  function automatic hann_result_t hann_coef(input int unsigned n);
    hann_result_t r;
    longint unsigned div;
    longint unsigned coef;
    logic [31:0] phase;
    longint x, y, z, dx, dy, c, v;
    r = '0;
    if (n >= win_size) begin
      r.out_of_range = 1'b1;
      return r;
    end
    div = periodic ? win_size : win_size - 1;
    phase = '0;
    if (div != 0) phase = (((longint'(n)) << 32) + (div >> 1)) / div;
    x = CORDIC_X0;
    y = 0;
    z = phase[QUARTER_BITS-1:0];
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TBL[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TBL[i];
      end
    end
    case (phase[31:30])
      2'd0: c = x;
      2'd1: c = -y;
      2'd2: c = -x;
      default: c = y;
    endcase
    v = (64'sd1 <<< 30) - c;
    if (v < 0) v = 0;
    if (v > (64'sd1 <<< 31)) v = 64'sd1 <<< 31;
    coef = (longint'(v) + (64'd1 << (30 - FRAC_BITS))) >> (31 - FRAC_BITS);
    if (coef > (64'd1 << FRAC_BITS)) coef = 64'd1 << FRAC_BITS;
    r.coefficient = coef[COEF_W-1:0];
    r.last_index = (n == win_size - 1);
    return r;
  endfunction

  // Result side: random stalls between transfers, checked in order.
  always @(posedge clk) begin
    hann_result_t want;
    if (rst_n && out_valid && out_ready) begin
      result_count++;
      if (pending_coefs.size() == 0) begin
        $error("unexpected result coefficient=%0d", out_coefficient);
        fail_count++;
      end else begin
        want = pending_coefs.pop_front();
        if (out_coefficient !== want.coefficient) begin
          $error("coefficient expected %0d actual %0d", want.coefficient, out_coefficient);
          fail_count++;
        end
        if (out_last_index !== want.last_index) begin
          $error("last_index expected %0d actual %0d", want.last_index, out_last_index);
          fail_count++;
        end
        if (out_out_of_range !== want.out_of_range) begin
          $error("out_of_range expected %0d actual %0d", want.out_of_range,
                 out_out_of_range);
          fail_count++;
        end
      end
      stall_left = no_gaps ? 0 : $urandom_range(0, 18);
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_index(input int unsigned n);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_sample_index <= IDX_W'(n);
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    pending_coefs = {pending_coefs, hann_coef(n)};
    index_count++;
  endtask

  // Waits until the pipeline has drained, then writes one register.
  task automatic write_reg(input logic reg_sel, input logic [31:0] value);
    in_valid <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= 3'(4 * reg_sel);
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (reg_sel == REG_WINDOW_SIZE)
      win_size = (value[12:0] > MAX_WINDOW) ? MAX_WINDOW : value[12:0];
    else
      periodic = value[0];
    setting_count++;
  endtask

  task automatic set_window(input logic [31:0] size, input bit mode);
    write_reg(REG_WINDOW_SIZE, size);
    write_reg(REG_PERIODIC, {31'd0, mode});
  endtask

  task automatic test_reset_defaults();
    send_index(0);
    send_index(1);
    send_index(512);
    send_index(1023);
    send_index(1024);
    send_index(4095);
  endtask

  task automatic test_full_window();
    set_window(MAX_WINDOW, 1'b1);
    send_index(0);
    send_index(2048);
    send_index(4095);
    // In symmetric mode the final index lands on the divisor and wraps to zero.
    set_window(MAX_WINDOW, 1'b0);
    send_index(2048);
    send_index(4095);
  endtask

  task automatic test_tiny_windows();
    set_window(2, 1'b0);
    send_index(0);
    send_index(1);
    send_index(2);
    // A one-entry symmetric window has a zero divisor.
    set_window(1, 1'b0);
    send_index(0);
    send_index(1);
    set_window(0, 1'b1);
    send_index(0);
    send_index(4095);
  endtask

  task automatic test_oversized_write();
    set_window(32'h0000_1FFF, 1'b1);
    send_index(4095);
    send_index(1000);
    set_window(32'hFFFF_F001, 1'b0);
    send_index(4095);
    send_index(0);
  endtask

  task automatic test_random_windows();
    int unsigned size;
    int unsigned n;
    for (int phase_no = 0; phase_no < 10; phase_no++) begin
      case ($urandom_range(0, 4))
        0: size = $urandom_range(2, 16);
        1: size = $urandom_range(2, MAX_WINDOW);
        2: size = MAX_WINDOW;
        3: size = $urandom_range(17, 300);
        default: size = $urandom_range(0, 8191);
      endcase
      set_window(size, 1'($urandom_range(0, 1)));
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < 100; k++) begin
        if (win_size != 0 && $urandom_range(0, 9) < 8) n = $urandom_range(0, win_size - 1);
        else n = $urandom_range(0, 4095);
        send_index(n);
      end
      no_gaps = 1'b0;
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_full_window();
    test_tiny_windows();
    test_oversized_write();
    test_random_windows();
    in_valid <= 1'b0;
    while (pending_coefs.size() != 0) @(posedge clk);
    repeat (70) @(posedge clk);
    $display("Sent %0d indices over %0d register writes and checked %0d coefficients.",
             index_count, setting_count, result_count);
    if (fail_count == 0 && pending_coefs.size() == 0) begin
      $display("hann_window_coefficient verification clean");
    end else begin
      $display("hann_window_coefficient verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("hann_window_coefficient verification failed");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/hwc_pkg.sv
hw/rtl/hwc_div_cell.sv
hw/rtl/hwc_cordic_cell.sv
hw/rtl/hann_window_coefficient.sv
verif/tb_top.sv
